// ===== hdl/ppm_frame_generator_assert.svh =====
// ----------------------------------------------------------------------------
// PPM frame generator assertion macros
// Shared property forms for the concurrent checks of the generator.
// ----------------------------------------------------------------------------
`ifndef PPM_FRAME_GENERATOR_ASSERT_SVH
`define PPM_FRAME_GENERATOR_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define PPM_ASSERT_HOLDS(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define PPM_ASSERT_NEXT(name, clk, rst, cond, expr, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ===== hdl/ppm_pkg.sv =====
// ----------------------------------------------------------------------------
// PPM frame generator package
// Defaults, register indexes, codes and types of the generator.
// ----------------------------------------------------------------------------
package ppm_pkg;

   localparam int MAX_CHANNELS_DEF = 16;
   localparam int VALUE_BITS_DEF   = 12;
   localparam int TIME_BITS_DEF    = 16;

   localparam int CENTER_VALUE = 1500;

   // Field widths fixed by the register map and the item layout
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam int COUNT_BITS     = 5;
   localparam int SYNC_BITS      = 10;
   localparam int FTIME_BITS     = 16;
   localparam int LIMIT_BITS     = 12;
   localparam int INDEX_BITS     = 4;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET      = 5'd8;
   localparam logic [SYNC_BITS-1:0]  SYNC_RESET       = 10'd300;
   localparam logic [FTIME_BITS-1:0] FRAME_SYNC_RESET = 16'd4000;
   localparam logic [FTIME_BITS-1:0] FRAME_LEN_RESET  = 16'd22500;
   localparam logic                  INVERT_RESET     = 1'b0;
   localparam logic [LIMIT_BITS-1:0] MIN_RESET        = 12'd988;
   localparam logic [LIMIT_BITS-1:0] MAX_RESET        = 12'd2012;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CHANNEL_COUNT    = 3'd0,
      CSR_SYNC_WIDTH       = 3'd1,
      CSR_FRAME_SYNC_WIDTH = 3'd2,
      CSR_FRAME_LENGTH     = 3'd3,
      CSR_INVERT_OUTPUT    = 3'd4,
      CSR_MIN_VALUE        = 3'd5,
      CSR_MAX_VALUE        = 3'd6
   } csr_index_type;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_SET  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_PRE  = 2'd1,
      ST_POST = 2'd2
   } seq_state_type;

   typedef struct packed {
      logic ppm_level;
      logic frame_start;
      logic set_accepted;
   } result_type;

endpackage

// ===== hdl/ppm_ram.sv =====
// ----------------------------------------------------------------------------
// PPM generic RAM
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ppm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // hold the last read word while idle
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ppm_frame_generator.sv =====
// ----------------------------------------------------------------------------
// PPM frame generator
// Results are registered to rsp once the item completes: a plain item
// completes in its accept cycle, a tick once it has entered its segments
// (the segment step logic enters one segment a cycle, channel store read
// one segment ahead). Throughput: one item per cycle when req_stall is low.
// Reset: config to defaults, frame timing to zero, channels read 1500.
// ----------------------------------------------------------------------------
`include "ppm_frame_generator_assert.svh"

module ppm_frame_generator #(
   parameter int MAX_CHANNELS = ppm_pkg::MAX_CHANNELS_DEF,
   parameter int VALUE_BITS   = ppm_pkg::VALUE_BITS_DEF,
   parameter int TIME_BITS    = ppm_pkg::TIME_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_operation,
   input  logic [ppm_pkg::INDEX_BITS-1:0]      req_channel_index,
   input  logic [VALUE_BITS-1:0]               req_channel_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_ppm_level,
   output logic                                rsp_frame_start,
   output logic                                rsp_set_accepted,
   input  logic                                csr_write,
   input  logic [ppm_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [ppm_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   localparam int CH_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CH_DEPTH = 1 << CH_W;
   localparam int SEG_W    = $clog2(2 * MAX_CHANNELS + 3);
   localparam int CNT_W    = $clog2(MAX_CHANNELS + 1);
   localparam int WIDE_W   = ((TIME_BITS > ppm_pkg::FTIME_BITS) ?
                              TIME_BITS : ppm_pkg::FTIME_BITS) + 1;
   localparam int IDX_W    = (CNT_W > ppm_pkg::INDEX_BITS) ? CNT_W : ppm_pkg::INDEX_BITS;
   localparam int LIM_W    = (VALUE_BITS > ppm_pkg::LIMIT_BITS) ?
                             VALUE_BITS : ppm_pkg::LIMIT_BITS;
   localparam int DV_W     = (VALUE_BITS > ppm_pkg::SYNC_BITS) ?
                             VALUE_BITS : ppm_pkg::SYNC_BITS;

   localparam logic [WIDE_W-1:0]     TIME_MAX_WIDE = WIDE_W'((1 << TIME_BITS) - 1);
   localparam logic [VALUE_BITS-1:0] CENTER_WORD   = VALUE_BITS'(ppm_pkg::CENTER_VALUE);

   function automatic logic [TIME_BITS-1:0] sat_time(input logic [WIDE_W-1:0] v);
      return (v > TIME_MAX_WIDE) ? TIME_MAX_WIDE[TIME_BITS-1:0] : v[TIME_BITS-1:0];
   endfunction

   // Configuration registers
   logic [ppm_pkg::COUNT_BITS-1:0] cc_ff;
   logic [ppm_pkg::SYNC_BITS-1:0]  sw_ff;
   logic [ppm_pkg::FTIME_BITS-1:0] fsw_ff;
   logic [ppm_pkg::FTIME_BITS-1:0] fl_ff;
   logic                           inv_ff;
   logic [ppm_pkg::LIMIT_BITS-1:0] minv_ff;
   logic [ppm_pkg::LIMIT_BITS-1:0] maxv_ff;

   // Frame timing
   ppm_pkg::seq_state_type state_ff, state_in;
   logic [TIME_BITS-1:0]   ft_ff, ft_in;
   logic [SEG_W-1:0]       si_ff, si_in;
   logic [TIME_BITS-1:0]   se_ff, se_in;
   logic                   lvl_ff, lvl_in;
   logic                   started_ff, started_in;

   // Channel store slot bookkeeping: two slots per channel
   logic [CH_DEPTH-1:0]      pend_slot_ff, pend_slot_in;
   logic [CH_DEPTH-1:0]      act_slot_ff, act_slot_in;
   logic [1:0][CH_DEPTH-1:0] vld_ff, vld_in;
   logic                     rd_vld_ff, rd_vld_in;

   // Result buffer
   logic                   out_valid_ff, out_valid_in;
   ppm_pkg::result_type    out_ff, out_in;
   logic                   skd_valid_ff, skd_valid_in;
   ppm_pkg::result_type    skd_ff, skd_in;

   // Combinational
   logic                   req_acc, tick_acc, set_acc, set_ok, start_c;
   logic [CNT_W-1:0]       eff_n;
   logic [SEG_W-1:0]       last_seg, si_nx;
   logic [TIME_BITS-1:0]   se_a, ft_inc, se_nx, se_sum, se_pad;
   logic                   si_lt_last, ge_now, ge_inc, enter_go, emit;
   logic [VALUE_BITS-1:0]  val_cur;
   logic [DV_W-1:0]        val_ext, sw_ext, ch_len;
   logic [WIDE_W-1:0]      add_len;
   logic [CH_W-1:0]        ch_nx, ch_wr;
   logic                   wr_slot;
   ppm_pkg::result_type    res_c;
   logic                   ram_wr_en, ram_rd_en;
   logic [CH_W:0]          ram_wr_addr, ram_rd_addr;
   logic [VALUE_BITS-1:0]  ram_rd_data;
   logic                   pop;

   ppm_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (2 * CH_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_channel_value),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         cc_ff   <= ppm_pkg::COUNT_RESET;
         sw_ff   <= ppm_pkg::SYNC_RESET;
         fsw_ff  <= ppm_pkg::FRAME_SYNC_RESET;
         fl_ff   <= ppm_pkg::FRAME_LEN_RESET;
         inv_ff  <= ppm_pkg::INVERT_RESET;
         minv_ff <= ppm_pkg::MIN_RESET;
         maxv_ff <= ppm_pkg::MAX_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            ppm_pkg::CSR_CHANNEL_COUNT:    cc_ff   <= csr_wdata[ppm_pkg::COUNT_BITS-1:0];
            ppm_pkg::CSR_SYNC_WIDTH:       sw_ff   <= csr_wdata[ppm_pkg::SYNC_BITS-1:0];
            ppm_pkg::CSR_FRAME_SYNC_WIDTH: fsw_ff  <= csr_wdata[ppm_pkg::FTIME_BITS-1:0];
            ppm_pkg::CSR_FRAME_LENGTH:     fl_ff   <= csr_wdata[ppm_pkg::FTIME_BITS-1:0];
            ppm_pkg::CSR_INVERT_OUTPUT:    inv_ff  <= csr_wdata[0];
            ppm_pkg::CSR_MIN_VALUE:        minv_ff <= csr_wdata[ppm_pkg::LIMIT_BITS-1:0];
            ppm_pkg::CSR_MAX_VALUE:        maxv_ff <= csr_wdata[ppm_pkg::LIMIT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // Handshake and decode
   assign req_stall = (state_ff != ppm_pkg::ST_IDLE) || skd_valid_ff;
   assign req_acc   = req_valid && !req_stall;
   assign tick_acc  = req_acc && (req_operation == ppm_pkg::OP_TICK);
   assign set_acc   = req_acc && (req_operation == ppm_pkg::OP_SET);

   assign eff_n    = (32'(cc_ff) > MAX_CHANNELS) ? CNT_W'(MAX_CHANNELS) : CNT_W'(cc_ff);
   assign last_seg = SEG_W'({eff_n, 1'b0}) + SEG_W'(2);

   assign set_ok = (IDX_W'(req_channel_index) < IDX_W'(eff_n))
                   && (LIM_W'(req_channel_value) >= LIM_W'(minv_ff))
                   && (LIM_W'(req_channel_value) <= LIM_W'(maxv_ff));

   // Segment timing compares
   assign start_c    = (state_ff == ppm_pkg::ST_IDLE) && (ft_ff == '0) && (si_ff == '0);
   assign se_a       = start_c ? sat_time(WIDE_W'(fsw_ff)) : se_ff;
   assign ft_inc     = sat_time(WIDE_W'(ft_ff) + WIDE_W'(1));
   assign si_lt_last = si_ff < last_seg;
   assign ge_now     = ft_ff >= se_a;
   assign ge_inc     = ft_inc >= se_a;

   // Next segment: length from sync width, channel value or padding target
   assign si_nx   = si_ff + SEG_W'(1);
   assign val_cur = rd_vld_ff ? ram_rd_data : CENTER_WORD;
   assign val_ext = DV_W'(val_cur);
   assign sw_ext  = DV_W'(sw_ff);
   assign ch_len  = (val_ext > sw_ext) ? (val_ext - sw_ext) : '0;
   assign add_len = si_nx[0] ? WIDE_W'(sw_ff) : WIDE_W'(ch_len);
   assign se_sum  = sat_time(WIDE_W'(se_a) + add_len);
   assign se_pad  = (WIDE_W'(fl_ff) >= WIDE_W'(se_a)) ? sat_time(WIDE_W'(fl_ff)) : se_a;
   assign se_nx   = (si_nx == last_seg) ? se_pad : se_sum;

   // Segment sequencer
   always_comb begin
      state_in   = state_ff;
      ft_in      = ft_ff;
      si_in      = si_ff;
      se_in      = se_ff;
      lvl_in     = lvl_ff;
      started_in = started_ff;
      enter_go   = 1'b0;
      emit       = 1'b0;
      res_c      = '{ppm_level: lvl_ff, frame_start: 1'b0, set_accepted: 1'b0};
      unique case (state_ff)
         ppm_pkg::ST_IDLE: begin
            if (tick_acc) begin
               started_in = start_c;
               se_in      = se_a;
               if (ge_now && si_lt_last) begin
                  enter_go = 1'b1;
                  state_in = ppm_pkg::ST_PRE;
               end else begin
                  lvl_in = si_ff[0] ^ inv_ff;
                  ft_in  = ft_inc;
                  if (ge_inc && si_lt_last) begin
                     enter_go = 1'b1;
                     state_in = ppm_pkg::ST_POST;
                  end else begin
                     emit = 1'b1;
                     if (!si_lt_last && ge_inc) begin
                        ft_in = '0;
                        si_in = '0;
                        se_in = '0;
                     end
                  end
               end
            end else if (set_acc) begin
               emit = 1'b1;
               res_c.set_accepted = set_ok;
            end
         end
         ppm_pkg::ST_PRE: begin
            if (ge_now && si_lt_last) begin
               enter_go = 1'b1;
            end else begin
               lvl_in = si_ff[0] ^ inv_ff;
               ft_in  = ft_inc;
               if (ge_inc && si_lt_last) begin
                  enter_go = 1'b1;
                  state_in = ppm_pkg::ST_POST;
               end else begin
                  emit     = 1'b1;
                  state_in = ppm_pkg::ST_IDLE;
                  if (!si_lt_last && ge_inc) begin
                     ft_in = '0;
                     si_in = '0;
                     se_in = '0;
                  end
               end
            end
         end
         ppm_pkg::ST_POST: begin
            if (ge_now && si_lt_last) begin
               enter_go = 1'b1;
            end else begin
               emit     = 1'b1;
               state_in = ppm_pkg::ST_IDLE;
               if (!si_lt_last && ge_now) begin
                  ft_in = '0;
                  si_in = '0;
                  se_in = '0;
               end
            end
         end
         default: begin
            state_in = ppm_pkg::ST_IDLE;
         end
      endcase
      if (enter_go) begin
         si_in = si_nx;
         se_in = se_nx;
      end
      if (emit && !set_acc) begin
         res_c.ppm_level   = lvl_in;
         res_c.frame_start = started_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ppm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Channel store: sets go to the slot that is not active, frame start
   // makes the pending slots active
   assign ch_wr       = CH_W'(req_channel_index);
   assign wr_slot     = (pend_slot_ff[ch_wr] == act_slot_ff[ch_wr]) ?
                        !act_slot_ff[ch_wr] : pend_slot_ff[ch_wr];
   assign ram_wr_en   = set_acc && set_ok;
   assign ram_wr_addr = {wr_slot, ch_wr};

   // Fetch the value of the channel segment that follows an entered sync
   assign ch_nx       = CH_W'(si_nx[SEG_W-1:1]);
   assign act_slot_in = (tick_acc && start_c) ? pend_slot_ff : act_slot_ff;
   assign ram_rd_en   = enter_go && si_nx[0];
   assign ram_rd_addr = {act_slot_in[ch_nx], ch_nx};
   assign rd_vld_in   = ram_rd_en ? vld_ff[act_slot_in[ch_nx]][ch_nx] : rd_vld_ff;

   always_comb begin
      pend_slot_in = pend_slot_ff;
      vld_in       = vld_ff;
      if (ram_wr_en) begin
         pend_slot_in[ch_wr]     = wr_slot;
         vld_in[wr_slot][ch_wr]  = 1'b1;
      end
   end

   // Result buffer with skid stage
   assign pop = out_valid_ff && !rsp_stall;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      skd_valid_in = skd_valid_ff;
      skd_in       = skd_ff;
      if (pop || !out_valid_ff) begin
         if (skd_valid_ff) begin
            out_valid_in = 1'b1;
            out_in       = skd_ff;
            skd_valid_in = emit;
            skd_in       = res_c;
         end else begin
            out_valid_in = emit;
            out_in       = res_c;
         end
      end else if (emit) begin
         skd_valid_in = 1'b1;
         skd_in       = res_c;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ft_ff        <= '0;
         si_ff        <= '0;
         se_ff        <= '0;
         lvl_ff       <= ppm_pkg::INVERT_RESET;
         started_ff   <= 1'b0;
         pend_slot_ff <= '0;
         act_slot_ff  <= '0;
         vld_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
         skd_valid_ff <= 1'b0;
      end else begin
         ft_ff        <= ft_in;
         si_ff        <= si_in;
         se_ff        <= se_in;
         lvl_ff       <= lvl_in;
         started_ff   <= started_in;
         pend_slot_ff <= pend_slot_in;
         act_slot_ff  <= act_slot_in;
         vld_ff       <= vld_in;
         rd_vld_ff    <= rd_vld_in;
         out_valid_ff <= out_valid_in;
         skd_valid_ff <= skd_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      skd_ff <= skd_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_ppm_level    = out_ff.ppm_level;
   assign rsp_frame_start  = out_ff.frame_start;
   assign rsp_set_accepted = out_ff.set_accepted;

   `PPM_ASSERT_HOLDS(skid_behind_out, clock, reset, skd_valid_ff, out_valid_ff, "skid full while output empty")
   `PPM_ASSERT_HOLDS(busy_skid_empty, clock, reset, state_ff != ppm_pkg::ST_IDLE, !skd_valid_ff, "skid full during a multi-cycle tick")
   `PPM_ASSERT_NEXT(start_takes_pending, clock, reset, tick_acc && start_c, act_slot_ff == pend_slot_ff, "frame start did not take pending slots")
   `PPM_ASSERT_HOLDS(store_ports_apart, clock, reset, ram_wr_en, !ram_rd_en, "channel store written and read in one cycle")

endmodule

// ===== tb/ppm_frame_generator_test.sv =====
// ----------------------------------------------------------------------------
// PPM frame generator testbench
// Drives tick and channel-set items into the generator with random gaps and
// result stalls, predicts the line level, frame start and store flag of each
// item with a behavioral copy of the frame timing, and compares every result.
// ----------------------------------------------------------------------------
module ppm_frame_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   import ppm_pkg::*;

   localparam int TIME_MAX    = (1 << TIME_BITS_DEF) - 1;
   localparam int QUIET_LIMIT = 3000;
   localparam int RANDOM_ITEMS = 1450;
   localparam int REPORT_CAP  = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_operation = OP_TICK;
   logic [INDEX_BITS-1:0]     req_channel_index = '0;
   logic [VALUE_BITS_DEF-1:0] req_channel_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_ppm_level;
   logic                      rsp_frame_start;
   logic                      rsp_set_accepted;
   logic                      csr_write = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = CSR_CHANNEL_COUNT;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Frame timing copy of the generator
   logic [COUNT_BITS-1:0]     cfg_count  = COUNT_RESET;
   logic [SYNC_BITS-1:0]      cfg_sync   = SYNC_RESET;
   logic [FTIME_BITS-1:0]     cfg_fsync  = FRAME_SYNC_RESET;
   logic [FTIME_BITS-1:0]     cfg_flen   = FRAME_LEN_RESET;
   logic                      cfg_invert = INVERT_RESET;
   logic [LIMIT_BITS-1:0]     cfg_min    = MIN_RESET;
   logic [LIMIT_BITS-1:0]     cfg_max    = MAX_RESET;
   logic [VALUE_BITS_DEF-1:0] pend_val [MAX_CHANNELS_DEF] =
      '{default: VALUE_BITS_DEF'(CENTER_VALUE)};
   logic [VALUE_BITS_DEF-1:0] live_val [MAX_CHANNELS_DEF] =
      '{default: VALUE_BITS_DEF'(CENTER_VALUE)};
   int unsigned frame_tick = 0;
   int unsigned seg_idx    = 0;
   int unsigned seg_end    = 0;
   logic        line_lvl   = INVERT_RESET;

   result_type line_reports [$];

   logic idling = 1'b0;
   int   rsp_hold = 0;
   int   quiet_cycles = 0;
   int   error_count = 0;
   int   ticks_sent = 0;
   int   sets_sent = 0;
   int   sets_stored = 0;
   int   frames_begun = 0;
   int   setups_loaded = 0;

   ppm_frame_generator dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_operation     (req_operation),
      .req_channel_index (req_channel_index),
      .req_channel_value (req_channel_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_ppm_level     (rsp_ppm_level),
      .rsp_frame_start   (rsp_frame_start),
      .rsp_set_accepted  (rsp_set_accepted),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic int unsigned sat_time(int unsigned a, int unsigned b);
      return (a + b > TIME_MAX) ? TIME_MAX : a + b;
   endfunction

   function automatic int unsigned used_channels();
      return (32'(cfg_count) > MAX_CHANNELS_DEF) ? MAX_CHANNELS_DEF : 32'(cfg_count);
   endfunction

   // Enter every segment whose start time has been reached.
   function automatic void settle_segments();
      int unsigned last;
      int unsigned ch;
      int unsigned span;
      last = 2 * used_channels() + 2;
      while (frame_tick >= seg_end && seg_idx < last) begin
         seg_idx++;
         if (seg_idx == last) begin
            if (32'(cfg_flen) >= seg_end) seg_end = 32'(cfg_flen);
         end else if (seg_idx % 2 == 1) begin
            seg_end = sat_time(seg_end, 32'(cfg_sync));
         end else begin
            ch = (seg_idx - 2) / 2;
            span = (32'(live_val[ch]) > 32'(cfg_sync)) ?
                   32'(live_val[ch]) - 32'(cfg_sync) : 0;
            seg_end = sat_time(seg_end, span);
         end
      end
   endfunction

   function automatic result_type step_frame(op_type op, logic [INDEX_BITS-1:0] idx,
                                             logic [VALUE_BITS_DEF-1:0] val);
      result_type r;
      r = '0;
      if (op == OP_SET) begin
         if (32'(idx) < used_channels() && val >= cfg_min && val <= cfg_max) begin
            pend_val[idx] = val;
            r.set_accepted = 1'b1;
            sets_stored++;
         end
      end else begin
         if (frame_tick == 0 && seg_idx == 0) begin
            live_val = pend_val;
            seg_end = 32'(cfg_fsync);
            r.frame_start = 1'b1;
            frames_begun++;
         end
         settle_segments();
         line_lvl = (seg_idx % 2 == 1) ? ~cfg_invert : cfg_invert;
         frame_tick = sat_time(frame_tick, 1);
         settle_segments();
         if (seg_idx >= 2 * used_channels() + 2 && frame_tick >= seg_end) begin
            frame_tick = 0;
            seg_idx = 0;
            seg_end = 0;
         end
      end
      r.ppm_level = line_lvl;
      return r;
   endfunction

   task automatic send_item(input op_type op, input logic [INDEX_BITS-1:0] idx,
                            input logic [VALUE_BITS_DEF-1:0] val);
      if (idling && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_channel_index <= idx;
      req_channel_value <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      line_reports.push_back(step_frame(op, idx, val));
      if (op == OP_TICK) ticks_sent++;
      else sets_sent++;
   endtask

   task automatic send_random_tick();
      send_item(OP_TICK, INDEX_BITS'($urandom_range(0, 15)),
                VALUE_BITS_DEF'($urandom_range(0, 4095)));
   endtask

   // Wait until every predicted result is back and the block is quiet.
   task automatic finish_items();
      req_valid <= 1'b0;
      while (line_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type which, input logic [CSR_DATA_BITS-1:0] data);
      csr_write <= 1'b1;
      csr_index <= which;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic load_setup(input logic [COUNT_BITS-1:0] count,
                             input logic [SYNC_BITS-1:0] sync,
                             input logic [FTIME_BITS-1:0] fsync,
                             input logic [FTIME_BITS-1:0] flen,
                             input logic inv,
                             input logic [LIMIT_BITS-1:0] lo,
                             input logic [LIMIT_BITS-1:0] hi);
      finish_items();
      write_reg(CSR_CHANNEL_COUNT, CSR_DATA_BITS'(count));
      write_reg(CSR_SYNC_WIDTH, CSR_DATA_BITS'(sync));
      write_reg(CSR_FRAME_SYNC_WIDTH, fsync);
      write_reg(CSR_FRAME_LENGTH, flen);
      write_reg(CSR_INVERT_OUTPUT, CSR_DATA_BITS'(inv));
      write_reg(CSR_MIN_VALUE, CSR_DATA_BITS'(lo));
      write_reg(CSR_MAX_VALUE, CSR_DATA_BITS'(hi));
      csr_write <= 1'b0;
      cfg_count = count;
      cfg_sync = sync;
      cfg_fsync = fsync;
      cfg_flen = flen;
      cfg_invert = inv;
      cfg_min = lo;
      cfg_max = hi;
      setups_loaded++;
   endtask

   // Set limits and channel count at their reset values; no ticks, so the
   // long default frame is never entered.
   task automatic test_reset_limits();
      send_item(OP_SET, 0, 988);
      send_item(OP_SET, 7, 2012);
      send_item(OP_SET, 8, 1500);
      send_item(OP_SET, 15, 4095);
      send_item(OP_SET, 1, 987);
      send_item(OP_SET, 2, 2013);
      send_item(OP_SET, 3, 0);
   endtask

   // No channels and zero-length segments: every tick starts a frame.
   task automatic test_empty_frame();
      load_setup(0, 0, 0, 0, 1'b1, 0, 4095);
      send_item(OP_SET, 0, 5);
      repeat (3) send_item(OP_TICK, 4'hF, 12'hFFF);
      send_item(OP_SET, 0, 5);
      send_item(OP_TICK, 0, 0);
   endtask

   // Channel count above the channel maximum is capped at that maximum.
   task automatic test_channel_cap();
      load_setup(31, 1, 1, 0, 1'b0, 0, 4095);
      send_item(OP_SET, 15, 2);
      send_item(OP_SET, 0, 0);
      send_item(OP_SET, 9, 4095);
   endtask

   task automatic test_random_frames();
      logic [COUNT_BITS-1:0] count;
      logic [SYNC_BITS-1:0]  sync;
      logic [FTIME_BITS-1:0] fsync;
      logic [FTIME_BITS-1:0] flen;
      logic                  inv;
      logic [LIMIT_BITS-1:0] lo;
      logic [LIMIT_BITS-1:0] hi;
      int items_done;
      int phase;
      int n;
      int pick;
      items_done = 0;
      phase = 0;
      while (items_done < RANDOM_ITEMS) begin
         idling = ($urandom_range(0, 3) != 0);
         if (phase == 0) begin
            // fill the whole store with short values first
            count = 16; sync = 2; fsync = 3; flen = 0; inv = 1'b0; lo = 0; hi = 12;
         end else begin
            case ($urandom_range(0, 9))
               0: count = 0;
               1: count = 16;
               2: count = COUNT_BITS'($urandom_range(17, 31));
               default: count = COUNT_BITS'($urandom_range(1, 6));
            endcase
            sync = ($urandom_range(0, 7) == 0) ? SYNC_BITS'($urandom_range(7, 40)) :
                                                 SYNC_BITS'($urandom_range(0, 6));
            fsync = ($urandom_range(0, 5) == 0) ? FTIME_BITS'($urandom_range(13, 60)) :
                                                  FTIME_BITS'($urandom_range(0, 12));
            case ($urandom_range(0, 2))
               0: flen = 0;
               1: flen = FTIME_BITS'($urandom_range(0, 40));
               default: flen = FTIME_BITS'($urandom_range(40, 200));
            endcase
            inv = 1'($urandom_range(0, 1));
            lo = ($urandom_range(0, 9) == 0) ? LIMIT_BITS'($urandom_range(20, 40)) :
                                               LIMIT_BITS'($urandom_range(0, 8));
            case ($urandom_range(0, 11))
               0: hi = 0;
               1: hi = (lo > 0) ? lo - LIMIT_BITS'(1) : '0;
               default: hi = LIMIT_BITS'(32'(lo) + $urandom_range(0, 30));
            endcase
            // every segment of zero length
            if (phase % 6 == 0) begin
               sync = 0; fsync = 0; flen = 0; lo = 0; hi = 0;
            end
         end
         load_setup(count, sync, fsync, flen, inv, lo, hi);
         n = used_channels();
         for (int ch = 0; ch < n; ch++) begin
            send_item(OP_SET, INDEX_BITS'(ch),
                      VALUE_BITS_DEF'((lo <= hi) ? $urandom_range(hi, lo) :
                                                   $urandom_range(0, 4095)));
            items_done++;
         end
         repeat ($urandom_range(40, 130)) begin
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
               send_random_tick();
               items_done++;
            end else if (pick < 92 && n > 0 && lo <= hi) begin
               send_item(OP_SET, INDEX_BITS'($urandom_range(0, n - 1)),
                         VALUE_BITS_DEF'($urandom_range(hi, lo)));
               items_done++;
            end else begin
               send_item(OP_SET, INDEX_BITS'($urandom_range(0, 15)),
                         VALUE_BITS_DEF'($urandom_range(0, 4095)));
            end
         end
         phase++;
      end
   endtask

   // Channel values below, at and just past the sync width, with a frame
   // length the frame has already passed so no padding is added.
   task automatic test_short_channels();
      int target;
      idling = 1'b0;
      while (frame_tick != 0 || seg_idx != 0)
         send_random_tick();
      load_setup(3, 9, 2, 5, 1'b1, 0, 4095);
      send_item(OP_SET, 0, 4);
      send_item(OP_SET, 1, 9);
      send_item(OP_SET, 2, 10);
      send_item(OP_SET, 3, 4095);
      target = frames_begun + 2;
      while (frames_begun < target)
         send_random_tick();
   endtask

   // Result-side stall bursts
   always @(posedge clock) begin
      if (rsp_hold > 1) begin
         rsp_hold <= rsp_hold - 1;
      end else if (idling && $urandom_range(0, 9) == 0) begin
         rsp_hold <= $urandom_range(1, 14);
         rsp_stall <= 1'b1;
      end else begin
         rsp_hold <= 0;
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_reports.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_CAP)
               $display("%0t: result with nothing predicted: level %b start %b stored %b",
                        $time, rsp_ppm_level, rsp_frame_start, rsp_set_accepted);
         end else begin
            want = line_reports.pop_front();
            if (rsp_ppm_level !== want.ppm_level) begin
               error_count++;
               if (error_count <= REPORT_CAP)
                  $display("%0t: ppm_level expected %b, actual %b",
                           $time, want.ppm_level, rsp_ppm_level);
            end
            if (rsp_frame_start !== want.frame_start) begin
               error_count++;
               if (error_count <= REPORT_CAP)
                  $display("%0t: frame_start expected %b, actual %b",
                           $time, want.frame_start, rsp_frame_start);
            end
            if (rsp_set_accepted !== want.set_accepted) begin
               error_count++;
               if (error_count <= REPORT_CAP)
                  $display("%0t: set_accepted expected %b, actual %b",
                           $time, want.set_accepted, rsp_set_accepted);
            end
         end
      end
   end

   // Watchdog: no item moving on either side for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
         $display("FAILURE");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_reset_limits();
      test_empty_frame();
      test_channel_cap();
      test_random_frames();
      test_short_channels();
      finish_items();
      repeat (40) @(posedge clock);
      $display("Run covered %0d ticks and %0d channel writes (%0d stored) over %0d setups.",
               ticks_sent, sets_sent, sets_stored, setups_loaded);
      $display("%0d frames began; the closing frames held channels shorter than the sync.",
               frames_begun);
      if (error_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ppm_pkg.sv
hdl/ppm_ram.sv
hdl/ppm_frame_generator.sv
tb/ppm_frame_generator_test.sv
